### sv/cbm_pkg.sv
// Shared types, codes and constants of the cartridge bank mapper.
// Depends on nothing; every other file of the block but cbm_store imports it.
`default_nettype none

package cbm_pkg;

    // Default sizes of the two stores
    localparam int unsigned ROM_BYTES_DEFAULT      = 1048576;
    localparam int unsigned RAM_BANK_LIMIT_DEFAULT = 16;

    // Widest physical addresses the banking logic can form
    localparam int unsigned ROM_PHYS_W = 23;  // 9-bit bank, 14-bit offset
    localparam int unsigned RAM_PHYS_W = 17;  // 4-bit bank, 13-bit offset
    localparam int unsigned ROM_LIMIT_W = 24; // holds ROM_BYTES up to 8 MiB

    // Stream word layout
    localparam int unsigned S_TDATA_W = 48;
    localparam int unsigned OP_W      = 2;

    // Opcodes
    localparam logic [OP_W-1:0] OP_READ  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd2;

    // Mapper kinds
    localparam logic [1:0] KIND_PLAIN = 2'd0;
    localparam logic [1:0] KIND_MBC1  = 2'd1;
    localparam logic [1:0] KIND_MBC2  = 2'd2;
    localparam logic [1:0] KIND_MBC5  = 2'd3;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_MAPPER_KIND     = 2'd0;
    localparam logic [1:0] REG_ROM_BANKS       = 2'd1;
    localparam logic [1:0] REG_RAM_BANKS       = 2'd2;
    localparam logic [1:0] REG_ROM_IMAGE_BYTES = 2'd3;

    // Source of a result byte
    localparam logic [1:0] SEL_OPEN = 2'd0;
    localparam logic [1:0] SEL_ROM  = 2'd1;
    localparam logic [1:0] SEL_RAM  = 2'd2;

    localparam logic [7:0] OPEN_BUS = 8'hFF;

    typedef struct packed {
        logic [1:0]  mapper_kind;
        logic [9:0]  rom_banks;
        logic [4:0]  ram_banks;
        logic [20:0] rom_image_bytes;
    } cfg_t;

    typedef struct packed {
        logic                  rom_en;
        logic                  rom_we;
        logic [ROM_PHYS_W-1:0] rom_addr;
        logic                  ram_en;
        logic                  ram_we;
        logic [RAM_PHYS_W-1:0] ram_addr;
        logic [7:0]            wdata;
    } mem_req_t;

    typedef struct packed {
        logic [1:0] sel;
        logic       fault;
    } rsp_t;

endpackage

`default_nettype wire

### sv/cartridge_bank_mapper_core.sv
// Cartridge bank mapper: one input word per clock, every word answered by
// one result word; the store read is registered at the accept edge, and the
// result is then taken into the output register. Throughput is set by the single port
// of each store: the ROM image and the cartridge RAM are synchronous memories
// with a registered read port, and each word makes at most one access to one
// of them, so a new word is taken every cycle while the output is drained.
// Bank register updates and store writes take effect at the accept edge, so
// the next word already sees them. Stores need no clearing pass after reset;
// reading a byte never loaded or written returns an unspecified value.
// Depends on cbm_pkg, cbm_apb_regs, cbm_decoder and cbm_store.
`default_nettype none

module cartridge_bank_mapper_core
    import cbm_pkg::*;
#(
    parameter int unsigned ROM_BYTES      = ROM_BYTES_DEFAULT,
    parameter int unsigned RAM_BANK_LIMIT = RAM_BANK_LIMIT_DEFAULT
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration port
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [3:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic      [31:0]          prdata,
    output logic                      pready,
    // input words
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [15:0] cpu_address, [23:16] bus_byte, [43:24] image_offset, [47:44] zero
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // [1:0] opcode
    input  wire logic [OP_W-1:0]      s_tuser,
    // result words
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [7:0] read_byte
    output logic      [7:0]           m_tdata,
    // [0] range_fault
    output logic                      m_tuser
);

    localparam int unsigned ROM_AW    = $clog2(ROM_BYTES);
    localparam int unsigned RAM_DEPTH = RAM_BANK_LIMIT * 8192;
    localparam int unsigned RAM_AW    = $clog2(RAM_DEPTH);

    cfg_t       cfg;
    mem_req_t   req;
    rsp_t       rsp;
    logic       fire;
    logic [7:0] rom_q;
    logic [7:0] ram_q;

    logic       s1_valid_reg;
    rsp_t       s1_rsp_reg;
    logic       s1_adv;
    logic       out_valid_reg;
    logic [7:0] out_data_reg;
    logic [7:0] out_data_next;
    logic       out_fault_reg;

    cbm_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cbm_decoder #(
        .ROM_BYTES      (ROM_BYTES),
        .RAM_BANK_LIMIT (RAM_BANK_LIMIT)
    ) u_decoder (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .fire         (fire),
        .opcode       (s_tuser),
        .cpu_address  (s_tdata[15:0]),
        .bus_byte     (s_tdata[23:16]),
        .image_offset (s_tdata[43:24]),
        .req          (req),
        .rsp          (rsp)
    );

    cbm_store #(
        .DEPTH (ROM_BYTES),
        .AW    (ROM_AW)
    ) u_rom_store (
        .clk   (clk),
        .en    (req.rom_en),
        .we    (req.rom_we),
        .addr  (req.rom_addr[ROM_AW-1:0]),
        .wdata (req.wdata),
        .rdata (rom_q)
    );

    cbm_store #(
        .DEPTH (RAM_DEPTH),
        .AW    (RAM_AW)
    ) u_ram_store (
        .clk   (clk),
        .en    (req.ram_en),
        .we    (req.ram_we),
        .addr  (req.ram_addr[RAM_AW-1:0]),
        .wdata (req.wdata),
        .rdata (ram_q)
    );

    // Accept while the store stage can move on
    assign s1_adv   = s1_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~s1_valid_reg | ~out_valid_reg | m_tready;
    assign fire     = s_tvalid & s_tready;

    // Pick the result byte from the store that answered
    always_comb
    begin
        case (s1_rsp_reg.sel)
            SEL_ROM: out_data_next = rom_q;
            SEL_RAM: out_data_next = ram_q;
            default: out_data_next = OPEN_BUS;
        endcase
    end

    // Store stage: hold while the output register is blocked
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            s1_rsp_reg <= rsp;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_data_reg  <= out_data_next;
            out_fault_reg <= s1_rsp_reg.fault;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_fault_reg;

endmodule

`default_nettype wire

### sv/cbm_store.sv
// Single-port synchronous byte store with a registered read port.
// Depends on nothing; used for both the ROM image and the cartridge RAM.
`default_nettype none

module cbm_store #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10
) (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire logic          we,
    input  wire logic [AW-1:0] addr,
    input  wire logic [7:0]    wdata,
    output logic      [7:0]    rdata
);

    logic [7:0] mem_array [DEPTH];
    logic [7:0] rdata_reg;

    // Write, or read into the output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_array[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_array[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### sv/cbm_apb_regs.sv
// APB configuration registers of the cartridge bank mapper.
// Depends on cbm_pkg for the register indexes and the cfg_t bundle.
`default_nettype none

module cbm_apb_regs
    import cbm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output cfg_t             cfg
);

    cfg_t       cfg_reg;
    logic [1:0] reg_index;
    logic       wr_en;

    assign reg_index = paddr[3:2];
    assign pready    = 1'b1;
    assign wr_en     = psel & penable & pwrite & pready;

    // Update the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mapper_kind     <= KIND_PLAIN;
            cfg_reg.rom_banks       <= 10'd2;
            cfg_reg.ram_banks       <= 5'd0;
            cfg_reg.rom_image_bytes <= 21'd0;
        end
        else if (wr_en)
        begin
            case (reg_index)
                REG_MAPPER_KIND:     cfg_reg.mapper_kind     <= pwdata[1:0];
                REG_ROM_BANKS:       cfg_reg.rom_banks       <= pwdata[9:0];
                REG_RAM_BANKS:       cfg_reg.ram_banks       <= pwdata[4:0];
                REG_ROM_IMAGE_BYTES: cfg_reg.rom_image_bytes <= pwdata[20:0];
                default: ;
            endcase
        end
    end

    // Return the addressed register
    always_comb
    begin
        case (reg_index)
            REG_MAPPER_KIND:     prdata = {30'd0, cfg_reg.mapper_kind};
            REG_ROM_BANKS:       prdata = {22'd0, cfg_reg.rom_banks};
            REG_RAM_BANKS:       prdata = {27'd0, cfg_reg.ram_banks};
            REG_ROM_IMAGE_BYTES: prdata = {11'd0, cfg_reg.rom_image_bytes};
            default:             prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### sv/cbm_decoder.sv
// Bank registers and address translation of the cartridge bank mapper.
// Depends on cbm_pkg; drives the store requests and the result selection.
`default_nettype none

module cbm_decoder
    import cbm_pkg::*;
#(
    parameter int unsigned ROM_BYTES      = ROM_BYTES_DEFAULT,
    parameter int unsigned RAM_BANK_LIMIT = RAM_BANK_LIMIT_DEFAULT
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire cfg_t            cfg,
    input  wire logic            fire,
    input  wire logic [OP_W-1:0] opcode,
    input  wire logic [15:0]     cpu_address,
    input  wire logic [7:0]      bus_byte,
    input  wire logic [19:0]     image_offset,
    output mem_req_t             req,
    output rsp_t                 rsp
);

    localparam logic [ROM_LIMIT_W-1:0] ROM_CAPACITY = ROM_LIMIT_W'(ROM_BYTES);
    localparam logic [4:0]             RAM_LIMIT    = 5'(RAM_BANK_LIMIT);

    logic [8:0] rom_bank_reg, rom_bank_next;
    logic [3:0] ram_bank_reg, ram_bank_next;
    logic       ram_enable_reg, ram_enable_next;
    logic       adv_mode_reg, adv_mode_next;

    logic [4:0]             eff_banks;
    logic                   ram_on;
    logic [9:0]             rom_mask;
    logic [3:0]             ram_mask;
    logic [ROM_LIMIT_W-1:0] rom_limit;
    logic [ROM_LIMIT_W-1:0] image_len;
    logic [8:0]             rom_bank_sel;
    logic [ROM_PHYS_W-1:0]  rom_phys;
    logic                   rom_fault;
    logic [3:0]             ram_bank_idx;
    logic [12:0]            ram_off;
    logic [RAM_PHYS_W-1:0]  ram_phys;
    logic                   ram_fault;
    logic                   in_ram_window;
    logic                   is_mbc1;
    mem_req_t               req_raw;

    // Derive masks, limits and the translated addresses
    always_comb
    begin
        is_mbc1 = (cfg.mapper_kind == KIND_MBC1);

        if (cfg.mapper_kind == KIND_MBC2)
        begin
            eff_banks = 5'd1;
        end
        else if (cfg.ram_banks > RAM_LIMIT)
        begin
            eff_banks = RAM_LIMIT;
        end
        else
        begin
            eff_banks = cfg.ram_banks;
        end

        ram_on   = (eff_banks != 5'd0) &&
                   ((cfg.mapper_kind == KIND_PLAIN) || ram_enable_reg);
        rom_mask = cfg.rom_banks - 10'd1;
        ram_mask = 4'(eff_banks - 5'd1);

        image_len = ROM_LIMIT_W'(cfg.rom_image_bytes);
        rom_limit = (image_len > ROM_CAPACITY) ? ROM_CAPACITY : image_len;

        // ROM: window below 0x4000 holds bank 0 but in MBC1 advanced mode, switched window above it
        if (cpu_address[15:14] == 2'b00)
        begin
            rom_bank_sel = (is_mbc1 && adv_mode_reg) ?
                           ({2'b00, ram_bank_reg[1:0], 5'd0} & rom_mask[8:0]) : 9'd0;
        end
        else if (is_mbc1)
        begin
            rom_bank_sel = {2'b00, ram_bank_reg[1:0], rom_bank_reg[4:0]} & rom_mask[8:0];
        end
        else
        begin
            rom_bank_sel = rom_bank_reg & rom_mask[8:0];
        end
        rom_phys  = {rom_bank_sel, cpu_address[13:0]};
        rom_fault = ({1'b0, rom_phys} >= rom_limit);

        // RAM: bank per kind, MBC2 mirrors 512 nibbles
        case (cfg.mapper_kind)
            KIND_MBC1: ram_bank_idx = adv_mode_reg ? (ram_bank_reg & ram_mask) : 4'd0;
            KIND_MBC5: ram_bank_idx = ram_bank_reg & ram_mask;
            default:   ram_bank_idx = 4'd0;
        endcase
        ram_off   = (cfg.mapper_kind == KIND_MBC2) ? {4'd0, cpu_address[8:0]}
                                                   : cpu_address[12:0];
        ram_phys  = {ram_bank_idx, ram_off};
        ram_fault = ({1'b0, ram_bank_idx} >= eff_banks);

        in_ram_window = cpu_address inside {[16'hA000:16'hBFFF]};
    end

    // Decode the item into store requests and bank register updates
    always_comb
    begin
        rom_bank_next   = rom_bank_reg;
        ram_bank_next   = ram_bank_reg;
        ram_enable_next = ram_enable_reg;
        adv_mode_next   = adv_mode_reg;

        req_raw          = '0;
        req_raw.rom_addr = rom_phys;
        req_raw.ram_addr = ram_phys;
        req_raw.wdata    = bus_byte;
        rsp.sel          = SEL_OPEN;
        rsp.fault        = 1'b0;

        case (opcode)
            OP_READ:
            begin
                if (cpu_address[15] == 1'b0)
                begin
                    rsp.fault = rom_fault;
                    if (!rom_fault)
                    begin
                        req_raw.rom_en = 1'b1;
                        rsp.sel        = SEL_ROM;
                    end
                end
                else if (in_ram_window && ram_on)
                begin
                    rsp.fault = ram_fault;
                    if (!ram_fault)
                    begin
                        req_raw.ram_en = 1'b1;
                        rsp.sel        = SEL_RAM;
                    end
                end
            end

            OP_WRITE:
            begin
                case (cfg.mapper_kind)
                    KIND_MBC1:
                    begin
                        if (cpu_address < 16'h2000)
                        begin
                            ram_enable_next = (bus_byte[3:0] == 4'hA);
                        end
                        else if (cpu_address < 16'h4000)
                        begin
                            rom_bank_next = (bus_byte[4:0] != 5'd0) ?
                                            {4'd0, bus_byte[4:0]} : 9'd1;
                        end
                        else if (cpu_address < 16'h6000)
                        begin
                            ram_bank_next = {2'b00, bus_byte[1:0]};
                        end
                        else if (cpu_address < 16'h8000)
                        begin
                            adv_mode_next = bus_byte[0];
                        end
                    end
                    KIND_MBC2:
                    begin
                        if (cpu_address < 16'h4000)
                        begin
                            if (cpu_address[8])
                            begin
                                rom_bank_next = (bus_byte[3:0] != 4'd0) ?
                                                {5'd0, bus_byte[3:0]} : 9'd1;
                            end
                            else
                            begin
                                ram_enable_next = (bus_byte[3:0] == 4'hA);
                            end
                        end
                    end
                    KIND_MBC5:
                    begin
                        if (cpu_address < 16'h2000)
                        begin
                            ram_enable_next = (bus_byte[3:0] == 4'hA);
                        end
                        else if (cpu_address < 16'h3000)
                        begin
                            rom_bank_next = {rom_bank_reg[8], bus_byte};
                        end
                        else if (cpu_address < 16'h4000)
                        begin
                            rom_bank_next = {bus_byte[0], rom_bank_reg[7:0]};
                        end
                        else if (cpu_address < 16'h6000)
                        begin
                            ram_bank_next = bus_byte[3:0] & ram_mask;
                        end
                    end
                    default: ;
                endcase

                if (in_ram_window && ram_on)
                begin
                    rsp.fault = ram_fault;
                    if (!ram_fault)
                    begin
                        req_raw.ram_en = 1'b1;
                        req_raw.ram_we = 1'b1;
                        if (cfg.mapper_kind == KIND_MBC2)
                        begin
                            req_raw.wdata = {4'hF, bus_byte[3:0]};
                        end
                    end
                end
            end

            OP_LOAD:
            begin
                if (ROM_LIMIT_W'(image_offset) < ROM_CAPACITY)
                begin
                    req_raw.rom_en   = 1'b1;
                    req_raw.rom_we   = 1'b1;
                    req_raw.rom_addr = ROM_PHYS_W'(image_offset);
                end
                else
                begin
                    rsp.fault = 1'b1;
                end
            end

            default: ;
        endcase

        req        = req_raw;
        req.rom_en = req_raw.rom_en & fire;
        req.ram_en = req_raw.ram_en & fire;
    end

    // Hold the bank registers, advance them on an accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_bank_reg   <= 9'd1;
            ram_bank_reg   <= 4'd0;
            ram_enable_reg <= 1'b0;
            adv_mode_reg   <= 1'b0;
        end
        else if (fire)
        begin
            rom_bank_reg   <= rom_bank_next;
            ram_bank_reg   <= ram_bank_next;
            ram_enable_reg <= ram_enable_next;
            adv_mode_reg   <= adv_mode_next;
        end
    end

endmodule

`default_nettype wire

### bench/cartridge_bank_mapper_core_test.sv
// Self-checking bench for the cartridge bank mapper core: drives access words
// and register writes, predicts every result word and compares it on arrival.
// Depends on cbm_pkg and cartridge_bank_mapper_core.

module cartridge_bank_mapper_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import cbm_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
    localparam int QUIET_LIMIT      = 1000;
    localparam int SETTLE_CYCLES    = 4;
    localparam int PHASES           = 12;
    localparam int WORDS_PER_PHASE  = 64;
    localparam int MAX_REPORTS      = 200;

    typedef enum int {HIT_OPEN, HIT_ROM, HIT_RAM, HIT_FAULT} target_t;

    typedef struct packed {
        logic [7:0] data;
        logic       fault;
    } answer_t;

    // Mirror of the mapper: bank registers, stores and the answers still owed
    class bank_mapper_mirror;
        logic [1:0]  kind;
        logic [9:0]  rom_banks;
        logic [4:0]  ram_banks;
        logic [20:0] image_len;
        logic [8:0]  rom_bank;
        logic [3:0]  ram_bank;
        logic        ram_en;
        logic        adv_mode;
        logic [7:0]  rom_image [int];
        logic [7:0]  cart_ram [int];
        answer_t     awaited [$];
        int          errors;

        function new();
            kind      = KIND_PLAIN;
            rom_banks = 10'd2;
            ram_banks = 5'd0;
            image_len = 21'd0;
            rom_bank  = 9'd1;
            ram_bank  = 4'd0;
            ram_en    = 1'b0;
            adv_mode  = 1'b0;
            errors    = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_MAPPER_KIND:     kind      = value[1:0];
                REG_ROM_BANKS:       rom_banks = value[9:0];
                REG_RAM_BANKS:       ram_banks = value[4:0];
                REG_ROM_IMAGE_BYTES: image_len = value[20:0];
                default: ;
            endcase
        endfunction

        // MBC2 always carries one bank; others clamp at the store size
        function int ram_bank_total();
            if (kind == KIND_MBC2)
                return 1;
            if (ram_banks > RAM_BANK_LIMIT_DEFAULT)
                return int'(RAM_BANK_LIMIT_DEFAULT);
            return int'(ram_banks);
        endfunction

        function bit ram_reachable();
            if (ram_bank_total() == 0)
                return 1'b0;
            if (kind == KIND_PLAIN)
                return 1'b1;
            return ram_en;
        endfunction

        // A zero bank count wraps to an all-ones mask
        function int rom_mask();
            return (int'(rom_banks) - 1) & 'h3FF;
        endfunction

        function int ram_mask();
            return (ram_bank_total() - 1) & 'hF;
        endfunction

        function int rom_limit();
            if (image_len > ROM_BYTES_DEFAULT)
                return int'(ROM_BYTES_DEFAULT);
            return int'(image_len);
        endfunction

        // Translate a CPU address into the store it reaches and its offset there
        function target_t locate(logic [15:0] addr, output int phys);
            int bank;
            int off;
            phys = 0;
            if (addr < 16'h4000)
            begin
                phys = int'(addr);
                if (kind == KIND_MBC1 && adv_mode)
                    phys += 'h4000 * ((int'(ram_bank[1:0]) << 5) & rom_mask());
                if (phys >= rom_limit())
                    return HIT_FAULT;
                return HIT_ROM;
            end
            if (addr < 16'h8000)
            begin
                bank = int'(rom_bank);
                if (kind == KIND_MBC1)
                    bank = (int'(ram_bank[1:0]) << 5) | int'(rom_bank[4:0]);
                phys = 'h4000 * (bank & rom_mask()) + int'(addr) - 'h4000;
                if (phys >= rom_limit())
                    return HIT_FAULT;
                return HIT_ROM;
            end
            if (addr >= 16'hA000 && addr < 16'hC000 && ram_reachable())
            begin
                off = int'(addr[12:0]);
                case (kind)
                    KIND_MBC1: phys = ((adv_mode ? (int'(ram_bank) & ram_mask()) : 0) << 13)
                                      | off;
                    KIND_MBC2: phys = int'(addr[8:0]);
                    KIND_MBC5: phys = 'h2000 * (int'(ram_bank) & ram_mask()) + off;
                    default:   phys = off;
                endcase
                if (phys >= 8192 * ram_bank_total())
                    return HIT_FAULT;
                return HIT_RAM;
            end
            return HIT_OPEN;
        endfunction

        // Register side effects of a CPU write, per mapper kind
        function void update_bank_regs(logic [15:0] addr, logic [7:0] data);
            case (kind)
                KIND_MBC1:
                begin
                    if (addr < 16'h2000)
                        ram_en = (data[3:0] == 4'hA);
                    else if (addr < 16'h4000)
                        rom_bank = (data[4:0] == 5'd0) ? 9'd1 : {4'd0, data[4:0]};
                    else if (addr < 16'h6000)
                        ram_bank = {2'd0, data[1:0]};
                    else if (addr < 16'h8000)
                        adv_mode = data[0];
                end
                KIND_MBC2:
                begin
                    if (addr < 16'h4000)
                    begin
                        if (addr[8])
                            rom_bank = (data[3:0] == 4'd0) ? 9'd1 : {5'd0, data[3:0]};
                        else
                            ram_en = (data[3:0] == 4'hA);
                    end
                end
                KIND_MBC5:
                begin
                    if (addr < 16'h2000)
                        ram_en = (data[3:0] == 4'hA);
                    else if (addr < 16'h3000)
                        rom_bank = {rom_bank[8], data};
                    else if (addr < 16'h4000)
                        rom_bank = {data[0], rom_bank[7:0]};
                    else if (addr < 16'h6000)
                        ram_bank = data[3:0] & 4'(ram_mask());
                end
                default: ;
            endcase
        endfunction

        // Apply one accepted access word and queue the answer it owes
        function void note_access(logic [1:0] op, logic [15:0] addr, logic [7:0] data,
                                  logic [19:0] offset);
            answer_t ans;
            target_t hit;
            int      phys;
            ans.data  = OPEN_BUS;
            ans.fault = 1'b0;
            case (op)
                OP_READ:
                begin
                    hit = locate(addr, phys);
                    if (hit == HIT_ROM)
                        ans.data = rom_image[phys];
                    else if (hit == HIT_RAM)
                        ans.data = cart_ram[phys];
                    else if (hit == HIT_FAULT)
                        ans.fault = 1'b1;
                end
                OP_WRITE:
                begin
                    update_bank_regs(addr, data);
                    if (addr >= 16'hA000)
                    begin
                        hit = locate(addr, phys);
                        if (hit == HIT_RAM)
                            cart_ram[phys] = (kind == KIND_MBC2) ? {4'hF, data[3:0]} : data;
                        else if (hit == HIT_FAULT)
                            ans.fault = 1'b1;
                    end
                end
                OP_LOAD:
                begin
                    if (offset < ROM_BYTES_DEFAULT)
                        rom_image[int'(offset)] = data;
                    else
                        ans.fault = 1'b1;
                end
                default: ;
            endcase
            awaited.push_back(ans);
        endfunction

        // Compare one result word against the oldest owed answer
        function void check_answer(logic [7:0] data, logic fault);
            answer_t want;
            if (awaited.size() == 0)
            begin
                if (errors < MAX_REPORTS)
                    $display("%0t: result word with none owed: read_byte %h range_fault %b",
                             $time, data, fault);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (data !== want.data)
            begin
                if (errors < MAX_REPORTS)
                    $display("%0t: read_byte expected %h actual %h", $time, want.data, data);
                errors++;
            end
            if (fault !== want.fault)
            begin
                if (errors < MAX_REPORTS)
                    $display("%0t: range_fault expected %b actual %b", $time, want.fault,
                             fault);
                errors++;
            end
        endfunction

        function void flag_leftovers();
            if (awaited.size() != 0)
            begin
                $display("%0t: %0d result words never arrived", $time, awaited.size());
                errors += awaited.size();
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [3:0]           paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [OP_W-1:0]      s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [7:0]           m_tdata;
    logic                 m_tuser;

    bank_mapper_mirror mirror;
    bit                sender_calm = 1'b0;
    int                quiet_cycles = 0;

    cartridge_bank_mapper_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    // Check every result word taken by the sink
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && m_tvalid && m_tready)
            mirror.check_answer(m_tdata, m_tuser);
    end

    // End the run when no word moves on either side for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result sink: short stalls mostly, a few long ones, some long ready stretches
    initial
    begin : result_sink
        int r;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            r = $urandom_range(0, 99);
            if (r < 20)
            begin
                m_tready <= 1'b0;
                repeat ((r < 3) ? $urandom_range(10, 40) : $urandom_range(1, 3))
                    @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ((r >= 90) ? $urandom_range(50, 150) : $urandom_range(1, 6))
                @(posedge clk);
        end
    end

    function automatic int sender_gap();
        int r;
        if (sender_calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one access word, hold it until taken, then record it
    task automatic push_word(logic [1:0] op, logic [15:0] addr, logic [7:0] data,
                             logic [19:0] offset);
        int gap;
        gap = sender_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'd0, offset, data, addr};
        do
            @(posedge clk);
        while (!s_tready);
        mirror.note_access(op, addr, data, offset);
    endtask

    // Send an access; before a read of a never-written byte, write that byte first
    task automatic issue(logic [1:0] op, logic [15:0] addr, logic [7:0] data,
                         logic [19:0] offset);
        int      phys;
        target_t hit;
        if (op == OP_READ)
        begin
            hit = mirror.locate(addr, phys);
            if (hit == HIT_ROM && !mirror.rom_image.exists(phys))
                push_word(OP_LOAD, 16'($urandom), 8'($urandom), 20'(phys));
            else if (hit == HIT_RAM && !mirror.cart_ram.exists(phys))
                push_word(OP_WRITE, addr, 8'($urandom), 20'($urandom));
        end
        push_word(op, addr, data, offset);
    endtask

    task automatic access(logic [1:0] op, logic [15:0] addr, logic [7:0] data);
        issue(op, addr, data, 20'($urandom));
    endtask

    // Drop valid and hold until every owed result word has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (mirror.awaited.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        mirror.set_register(idx, value);
    endtask

    task automatic configure(logic [1:0] kind, int roms, int rams, int img);
        drain_results();
        write_reg(REG_MAPPER_KIND, 32'(kind));
        write_reg(REG_ROM_BANKS, 32'(roms));
        write_reg(REG_RAM_BANKS, 32'(rams));
        write_reg(REG_ROM_IMAGE_BYTES, 32'(img));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic directed_sequence();
        // Reset settings: empty image, no RAM
        access(OP_READ, 16'h0000, 8'h00);
        issue(OP_LOAD, 16'hFFFF, 8'h00, 20'h00000);
        issue(OP_LOAD, 16'h0000, 8'hFF, 20'hFFFFF);
        access(OP_SPARE, 16'h1234, 8'h56);
        access(OP_READ, 16'hA000, 8'h00);
        access(OP_WRITE, 16'hBFFF, 8'h12);
        access(OP_READ, 16'h8000, 8'h00);
        access(OP_READ, 16'h9FFF, 8'h00);
        access(OP_READ, 16'hFFFF, 8'h00);
        // Plain cartridge: RAM open whenever present
        configure(KIND_PLAIN, 2, 1, 32768);
        access(OP_READ, 16'h7FFF, 8'h00);
        access(OP_WRITE, 16'hA000, 8'hFF);
        access(OP_READ, 16'hA000, 8'h00);
        access(OP_READ, 16'hBFFF, 8'h00);
        // MBC1: zero bank maps to one, advanced mode moves the low window
        configure(KIND_MBC1, 4, 4, 65536);
        access(OP_WRITE, 16'h2000, 8'h00);
        access(OP_WRITE, 16'h0000, 8'h0A);
        access(OP_WRITE, 16'h6000, 8'h01);
        access(OP_WRITE, 16'h4000, 8'h03);
        access(OP_READ, 16'hA123, 8'h00);
        access(OP_READ, 16'h0000, 8'h00);
        access(OP_WRITE, 16'h2000, 8'h1F);
        access(OP_READ, 16'h7FFF, 8'h00);
        // MBC2: nibble RAM mirrored through the window
        configure(KIND_MBC2, 16, 0, 262144);
        access(OP_WRITE, 16'h0100, 8'h00);
        access(OP_WRITE, 16'h3EFF, 8'h5A);
        access(OP_WRITE, 16'hA1FF, 8'h3C);
        access(OP_READ, 16'hBFFF, 8'h00);
        // MBC5: ninth bank bit, image length above the store
        configure(KIND_MBC5, 512, 16, 21'h1FFFFF);
        access(OP_WRITE, 16'h3000, 8'h01);
        access(OP_WRITE, 16'h2000, 8'hFF);
        access(OP_READ, 16'h7FFF, 8'h00);
        access(OP_WRITE, 16'h0000, 8'h0A);
        access(OP_WRITE, 16'h4000, 8'h0F);
        access(OP_WRITE, 16'hBFFF, 8'h81);
        access(OP_READ, 16'hBFFF, 8'h00);
    endtask

    // Pick settings for one phase, forcing the extremes on two of them
    task automatic configure_random(int phase);
        int roms;
        int rams;
        int img;
        case ($urandom_range(0, 9))
            0:       roms = $urandom_range(0, 1023);
            1:       roms = 0;
            default: roms = 1 << $urandom_range(1, 9);
        endcase
        case ($urandom_range(0, 9))
            0:       rams = $urandom_range(17, 31);
            1, 2:    rams = 0;
            default: rams = 1 << $urandom_range(0, 4);
        endcase
        img = roms * 16384;
        if (img > ROM_BYTES_DEFAULT)
            img = ROM_BYTES_DEFAULT;
        case ($urandom_range(0, 9))
            0:       img = $urandom_range(0, 21'h1FFFFF);
            1:       img = 21'h1FFFFF;
            default: ;
        endcase
        if (phase == 4)
        begin
            roms = 0;
            rams = 31;
            img  = 21'h1FFFFF;
        end
        else if (phase == 9)
        begin
            roms = 512;
            rams = 16;
            img  = ROM_BYTES_DEFAULT;
        end
        configure(2'(phase % 4), roms, rams, img);
    endtask

    // One random word: mostly reads and writes that exercise the banking rules
    task automatic random_access();
        int          r;
        logic [15:0] addr;
        logic [7:0]  data;
        r    = $urandom_range(0, 99);
        addr = 16'($urandom);
        data = 8'($urandom);
        if (r < 25)
        begin
            addr[15] = 1'b0;
            if ($urandom_range(0, 1))
                addr[13:0] = 14'($urandom_range(0, 15));
            issue(OP_READ, addr, data, 20'($urandom));
        end
        else if (r < 40)
        begin
            if ($urandom_range(0, 1))
                addr[12:0] = 13'($urandom_range(0, 15));
            issue(OP_READ, {3'b101, addr[12:0]}, data, 20'($urandom));
        end
        else if (r < 55)
            issue(OP_WRITE, {3'b101, addr[12:0]}, data, 20'($urandom));
        else if (r < 80)
        begin
            addr[15] = 1'b0;
            if ($urandom_range(0, 1))
                data[3:0] = 4'hA;
            issue(OP_WRITE, addr, data, 20'($urandom));
        end
        else if (r < 88)
            issue(2'($urandom), addr, data, 20'($urandom));
        else if (r < 94)
        begin
            addr = $urandom_range(0, 1) ? {3'b100, addr[12:0]} : {2'b11, addr[13:0]};
            issue($urandom_range(0, 1) ? OP_READ : OP_WRITE, addr, data, 20'($urandom));
        end
        else
            issue(OP_LOAD, addr, data, 20'($urandom));
    endtask

    initial
    begin : main_flow
        int phase;
        int n;
        mirror = new();
        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_sequence();

        for (phase = 0; phase < PHASES; phase++)
        begin
            configure_random(phase);
            sender_calm = (phase % 5 == 2);
            for (n = 0; n < WORDS_PER_PHASE; n++)
            begin
                // now and then let the pipe run dry before the next word
                if ($urandom_range(0, 59) == 0)
                    drain_results();
                random_access();
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        mirror.flag_leftovers();
        if (mirror.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
